@@ hw/rtl/ordered_list_engine_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Ordered list engine assertion macros
// Shared forms for the concurrent checks of the ordered list engine.
// ---------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_UNIT_DEFINES_SVH
`define ORDERED_LIST_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OLST_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OLST_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/olst_pkg.sv @@
// ---------------------------------------------------------------------------
// Ordered list engine package
// Field widths, command and status codes, and the cell control group.
// ---------------------------------------------------------------------------
package olst_pkg;

  localparam int CMD_W     = 3;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 8;
  localparam int STAT_W    = 3;
  localparam int CNT_W     = 7;
  localparam int DEPTH_DEF = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_INSERT     = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4,
    CMD_DELETE     = 3'd5,
    CMD_SEARCH     = 3'd6
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_BAD_POS   = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_op_t;

endpackage

@@ hw/rtl/olst_ifs.sv @@
// ---------------------------------------------------------------------------
// Ordered list engine channel interfaces
// Command channel and result channel, each with valid, ready and payload.
// ---------------------------------------------------------------------------
interface olst_in_if
  import olst_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;

  modport source (output valid, cmd, value, position, input ready);
  modport sink (input valid, cmd, value, position, output ready);
endinterface

interface olst_out_if
  import olst_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  found_position;
  logic [CNT_W-1:0]  entry_count;

  modport source (output valid, status, found_position, entry_count, input ready);
  modport sink (input valid, status, found_position, entry_count, output ready);
endinterface

@@ hw/rtl/ordered_list_engine_unit.sv @@
// ---------------------------------------------------------------------------
// Ordered list engine
// Bounded ordered list of 32-bit values kept in a row of shifting cells,
// with push, pop, positional insert, delete and search commands.
//
//   channel   dir  beat content
//   in_ch     in   cmd, value, position
//   out_ch    out  status, found_position, entry_count
//
// Each command is accepted, then executed: the accepting edge registers the
// compare of every cell against the value, and the executing edge in S_EXEC
// encodes the first match, shifts the cells and loads the result register.
// A waiting result stalls only the execute step; the next beat is taken
// as soon as the previous command has executed.
// Reset empties the list at once; slot contents are not cleared.
// ---------------------------------------------------------------------------
module ordered_list_engine_unit
  import olst_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int CW   = $clog2(DEPTH + 1),
  localparam int IW   = $clog2(DEPTH),
  localparam int XW   = (CW > CNT_W) ? CW : CNT_W,
  localparam int PW   = (CW > POS_W) ? CW : POS_W
) (
  input  logic        clk,
  input  logic        rst_n,
  olst_in_if.sink     in_ch,
  olst_out_if.source  out_ch
);

`include "ordered_list_engine_unit_defines.svh"

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CMD_W-1:0]   cmd_r;
  logic [VAL_W-1:0]   val_r;
  logic [POS_W-1:0]   pos_r;
  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  status_r;
  logic [CNT_W-1:0]   found_r;
  logic [CNT_W-1:0]   cnt_out_r;

  logic               accept;
  logic               fire;
  logic               full;
  logic               empty;
  logic               pos_ok;
  logic [POS_W-1:0]   pos_m1;
  logic [STAT_W-1:0]  res_status;
  logic [XW-1:0]      res_found;
  logic [XW-1:0]      cnt_ext;
  cell_op_t           op_raw, op;
  logic [IW-1:0]      k;
  logic               enc_any;
  logic [IW-1:0]      enc_idx;

  logic [DEPTH-1:0]   match;
  logic [VAL_W-1:0]   data_q  [DEPTH];
  logic [VAL_W-1:0]   left_d  [DEPTH];
  logic [VAL_W-1:0]   right_d [DEPTH];

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign fire        = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);

  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);
  assign pos_m1 = pos_r - POS_W'(1);
  assign pos_ok = (pos_r != '0) && (PW'(pos_r) <= PW'(count_r));

  always_comb begin
    op_raw     = '0;
    k          = '0;
    res_status = STAT_OK;
    res_found  = '0;
    count_nxt  = count_r;
    unique case (cmd_r)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (full) begin
          res_status = STAT_FULL;
        end else begin
          op_raw.ins = 1'b1;
          k          = (cmd_r == CMD_PUSH_FRONT) ? '0 : count_r[IW-1:0];
          count_nxt  = count_r + CW'(1);
        end
      end
      CMD_INSERT: begin
        priority if (full) begin
          res_status = STAT_FULL;
        end else if (!pos_ok) begin
          res_status = STAT_BAD_POS;
        end else begin
          op_raw.ins = 1'b1;
          k          = pos_m1[IW-1:0];
          count_nxt  = count_r + CW'(1);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (empty) begin
          res_status = STAT_EMPTY;
        end else begin
          op_raw.rem = 1'b1;
          k          = (cmd_r == CMD_POP_FRONT) ? '0 : IW'(count_r - CW'(1));
          count_nxt  = count_r - CW'(1);
        end
      end
      CMD_DELETE, CMD_SEARCH: begin
        priority if (empty) begin
          res_status = STAT_EMPTY;
        end else if (!enc_any) begin
          res_status = STAT_NOT_FOUND;
        end else if (cmd_r == CMD_DELETE) begin
          op_raw.rem = 1'b1;
          k          = enc_idx;
          count_nxt  = count_r - CW'(1);
        end else begin
          res_found = XW'(enc_idx) + XW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign op      = fire ? op_raw : '0;
  assign cnt_ext = XW'(count_nxt);

  olst_enc #(.DEPTH(DEPTH)) u_enc (
    .match (match),
    .any   (enc_any),
    .idx   (enc_idx)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_d[i] = val_r;
    end else begin : g_mid
      assign left_d[i] = data_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d[i] = data_q[i];
    end else begin : g_inner
      assign right_d[i] = data_q[i+1];
    end

    olst_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
      .clk        (clk),
      .cmp_en     (accept),
      .cmp_value  (in_ch.value),
      .count      (count_r),
      .op         (op),
      .k          (k),
      .load_value (val_r),
      .left_data  (left_d[i]),
      .right_data (right_d[i]),
      .data_r     (data_q[i]),
      .match_r    (match[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_ch.cmd;
      val_r <= in_ch.value;
      pos_r <= in_ch.position;
    end
    if (fire) begin
      status_r  <= res_status;
      found_r   <= res_found[CNT_W-1:0];
      cnt_out_r <= cnt_ext[CNT_W-1:0];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.found_position = found_r;
  assign out_ch.entry_count    = cnt_out_r;

  `OLST_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH), "count above depth")
  `OLST_ASSERT_NEXT(a_accept_exec, clk, rst_n, accept, state_r == S_EXEC, "accept without exec")
  `OLST_ASSERT_NEXT(a_fire_result, clk, rst_n, fire, out_valid_r, "executed command gave no result")
  `OLST_ASSERT_IMPL(a_full_status, clk, rst_n, fire && (res_status == STAT_FULL), full, "full status on a list with room")
  `OLST_ASSERT_NEXT(a_count_step, clk, rst_n, 1'b1, (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1)) || (count_r + CW'(1) == $past(count_r)), "count moved by more than one")

endmodule

@@ hw/rtl/olst_cell.sv @@
// ---------------------------------------------------------------------------
// Ordered list engine cell
// Holds one list slot, compares it against a search value and shifts it
// toward either neighbor to open or close a gap.
// ---------------------------------------------------------------------------
module olst_cell
  import olst_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX   = 0,
  localparam int CW   = $clog2(DEPTH + 1),
  localparam int IW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             cmp_en,
  input  logic [VAL_W-1:0] cmp_value,
  input  logic [CW-1:0]    count,
  input  cell_op_t         op,
  input  logic [IW-1:0]    k,
  input  logic [VAL_W-1:0] load_value,
  input  logic [VAL_W-1:0] left_data,
  input  logic [VAL_W-1:0] right_data,
  output logic [VAL_W-1:0] data_r,
  output logic             match_r
);

  logic [VAL_W-1:0] data_nxt;
  logic             match_nxt;
  logic             live;

  assign live = CW'(IDX) < count;

  always_comb begin
    data_nxt  = data_r;
    match_nxt = match_r;
    if (op.ins) begin
      if (IW'(IDX) == k) begin
        data_nxt = load_value;
      end else if (IW'(IDX) > k) begin
        data_nxt = left_data;
      end
    end else if (op.rem && (IW'(IDX) >= k)) begin
      data_nxt = right_data;
    end
    if (cmp_en) begin
      match_nxt = live && (data_r == cmp_value);
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

endmodule

@@ hw/rtl/olst_enc.sv @@
// ---------------------------------------------------------------------------
// Ordered list engine first-match encoder
// Isolates the lowest set match bit and encodes its slot index.
// ---------------------------------------------------------------------------
module olst_enc
  import olst_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int IW   = $clog2(DEPTH)
) (
  input  logic [DEPTH-1:0] match,
  output logic             any,
  output logic [IW-1:0]    idx
);

  logic [DEPTH-1:0] low_mask;
  logic [DEPTH-1:0] first;

  // Bits up to and including the lowest set bit, then that bit alone.
  assign low_mask = match ^ (match - DEPTH'(1));
  assign first    = match & low_mask;
  assign any      = |match;

  always_comb begin
    idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

endmodule

@@ dv/tb_ordered_list_engine_unit.sv @@
// ---------------------------------------------------------------------------
// Ordered list engine testbench
// Drives push, pop, positional insert, delete and search commands into the
// list engine, keeps a queue-based copy of the list to predict each result,
// and checks every result beat field by field under random stalls.
// ---------------------------------------------------------------------------
module tb_ordered_list_engine_unit;
  import olst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH     = DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 500;

  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] found_pos;
    logic [CNT_W-1:0] entry_count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n;

  olst_in_if  in_ch ();
  olst_out_if out_ch ();

  ordered_list_engine_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [VAL_W-1:0] list_model[$];
  list_result_t     pending_results[$];
  int unsigned      mismatches   = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      src_idle_pct = 15;
  int unsigned      snk_idle_pct = 15;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic list_result_t list_apply(cmd_t c, logic [VAL_W-1:0] v,
                                              logic [POS_W-1:0] p);
    list_result_t r;
    int           k;
    r.status    = STAT_OK;
    r.found_pos = '0;
    k           = -1;
    case (c)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (list_model.size() >= LIST_DEPTH) begin
          r.status = STAT_FULL;
        end else if (c == CMD_PUSH_FRONT) begin
          list_model.push_front(v);
        end else begin
          list_model.push_back(v);
        end
      end
      CMD_INSERT: begin
        if (list_model.size() >= LIST_DEPTH) begin
          r.status = STAT_FULL;
        end else if (p < 1 || p > list_model.size()) begin
          r.status = STAT_BAD_POS;
        end else begin
          list_model.insert(p - 1, v);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (list_model.size() == 0) begin
          r.status = STAT_EMPTY;
        end else if (c == CMD_POP_FRONT) begin
          void'(list_model.pop_front());
        end else begin
          void'(list_model.pop_back());
        end
      end
      CMD_DELETE, CMD_SEARCH: begin
        if (list_model.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          for (int i = 0; i < list_model.size(); i++) begin
            if (k < 0 && list_model[i] == v) k = i;
          end
          if (k < 0) begin
            r.status = STAT_NOT_FOUND;
          end else if (c == CMD_DELETE) begin
            list_model.delete(k);
          end else begin
            r.found_pos = CNT_W'(k + 1);
          end
        end
      end
      default: begin
      end
    endcase
    r.entry_count = CNT_W'(list_model.size());
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_cmd(cmd_t c, logic signed [VAL_W-1:0] v, logic [POS_W-1:0] p);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= c;
    in_ch.value    <= v;
    in_ch.position <= p;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(list_apply(c, v, p));
    @(negedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4 && list_model.size() != 0) begin
      return list_model[$urandom_range(0, list_model.size() - 1)];
    end
    // A narrow pool makes duplicates common, so the first match matters.
    if (sel < 7) return $urandom_range(0, 8) - 4;
    if (sel == 7) begin
      case ($urandom_range(0, 3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int unsigned sel;
    int          n;
    sel = $urandom_range(0, 9);
    n   = list_model.size();
    if (sel < 7 && n != 0) return POS_W'($urandom_range(1, n));
    if (sel == 7) return POS_W'(n + 1);
    if (sel == 8) return 0;
    return POS_W'($urandom_range(0, 255));
  endfunction

  task automatic random_ops(int n, int unsigned grow_pct);
    int unsigned sel;
    cmd_t        c;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < grow_pct) begin
        c = cmd_t'($urandom_range(int'(CMD_PUSH_FRONT), int'(CMD_INSERT)));
      end else if (sel < grow_pct + (100 - grow_pct) * 3 / 5) begin
        c = cmd_t'($urandom_range(int'(CMD_POP_FRONT), int'(CMD_POP_BACK)));
      end else begin
        c = cmd_t'($urandom_range(int'(CMD_DELETE), int'(CMD_SEARCH)));
      end
      send_cmd(c, pick_value(), pick_position());
    end
  endtask

  task automatic test_empty_list();
    send_cmd(CMD_POP_FRONT, 0, 0);
    send_cmd(CMD_POP_BACK, 0, 0);
    send_cmd(CMD_DELETE, 0, 0);
    send_cmd(CMD_SEARCH, -1, 0);
    send_cmd(CMD_INSERT, 5, 0);
    send_cmd(CMD_INSERT, 5, 1);
    send_cmd(CMD_INSERT, 5, 255);
  endtask

  task automatic test_single_entry();
    send_cmd(CMD_PUSH_BACK, 32'h7FFF_FFFF, 0);
    send_cmd(CMD_SEARCH, 32'h7FFF_FFFF, 0);
    send_cmd(CMD_POP_FRONT, 0, 0);
    send_cmd(CMD_PUSH_FRONT, 32'h8000_0000, 0);
    send_cmd(CMD_POP_BACK, 0, 0);
    send_cmd(CMD_PUSH_BACK, 0, 0);
    send_cmd(CMD_INSERT, -1, 1);
    send_cmd(CMD_INSERT, 32'h5555_5555, 2);
    send_cmd(CMD_INSERT, 32'hAAAA_AAAA, 4);
    send_cmd(CMD_INSERT, 32'hAAAA_AAAA, 3);
    send_cmd(CMD_SEARCH, 0, 0);
    send_cmd(CMD_DELETE, 32'h0001_2345, 0);
    send_cmd(CMD_DELETE, -1, 0);
    send_cmd(CMD_SEARCH, 0, 0);
    send_cmd(CMD_POP_BACK, 0, 0);
    send_cmd(CMD_POP_FRONT, 0, 0);
    send_cmd(CMD_POP_FRONT, 0, 0);
  endtask

  task automatic test_full_list();
    while (list_model.size() < LIST_DEPTH) begin
      if (list_model.size() != 0 && $urandom_range(0, 2) == 0) begin
        send_cmd(CMD_INSERT, $urandom, POS_W'($urandom_range(1, list_model.size())));
      end else begin
        send_cmd(cmd_t'($urandom_range(int'(CMD_PUSH_FRONT), int'(CMD_PUSH_BACK))),
                 $urandom, 0);
      end
    end
    // The full check takes precedence over the position check.
    send_cmd(CMD_PUSH_FRONT, 1, 0);
    send_cmd(CMD_PUSH_BACK, 2, 0);
    send_cmd(CMD_INSERT, 3, 0);
    send_cmd(CMD_INSERT, 3, 255);
    send_cmd(CMD_INSERT, 3, 1);
    send_cmd(CMD_SEARCH, list_model[LIST_DEPTH-1], 0);
    send_cmd(CMD_DELETE, list_model[LIST_DEPTH-1], 0);
    send_cmd(CMD_INSERT, 32'h8000_0000, POS_W'(LIST_DEPTH - 1));
    while (list_model.size() != 0) begin
      send_cmd(cmd_t'($urandom_range(int'(CMD_POP_FRONT), int'(CMD_DELETE))),
               pick_value(), 0);
    end
  endtask

  task automatic test_random_mix();
    int unsigned grow_pcts[6] = '{60, 25, 50, 70, 20, 50};
    int unsigned idle_pcts[3] = '{0, 10, 40};
    foreach (grow_pcts[i]) begin
      src_idle_pct = idle_pcts[$urandom_range(0, 2)];
      snk_idle_pct = idle_pcts[$urandom_range(0, 2)];
      random_ops(140, grow_pcts[i]);
    end
  endtask

  task automatic test_back_to_back();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    random_ops(110, 50);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < snk_idle_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    list_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with none expected, status %0d count %0d",
                 $time, out_ch.status, out_ch.entry_count);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.status !== exp_r.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d",
                   $time, exp_r.status, out_ch.status);
        end
        if (out_ch.found_position !== exp_r.found_pos) begin
          mismatches++;
          $display("%0t: found_position expected %0d actual %0d",
                   $time, exp_r.found_pos, out_ch.found_position);
        end
        if (out_ch.entry_count !== exp_r.entry_count) begin
          mismatches++;
          $display("%0t: entry_count expected %0d actual %0d",
                   $time, exp_r.entry_count, out_ch.entry_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_PUSH_FRONT;
    in_ch.value    = '0;
    in_ch.position = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_list();
    test_single_entry();
    test_full_list();
    test_random_mix();
    test_back_to_back();

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
